@@ src/kpc_pkg.sv @@
// Package with shared types, constants and mode codes for the key press classifier.
`default_nettype none

package kpc_pkg;

  localparam int TimeWidthDef = 32;
  localparam int NowWidth     = 32;
  localparam int ThrWidth     = 16;
  localparam int ModeWidth    = 3;
  localparam int CfgIdxWidth  = 2;
  localparam int InDataWidth  = 40;
  localparam int OutDataWidth = 8;

  localparam logic [ModeWidth-1:0] MODE_IDLE    = 3'd0;
  localparam logic [ModeWidth-1:0] MODE_DOWN    = 3'd1;
  localparam logic [ModeWidth-1:0] MODE_PRESSED = 3'd2;
  localparam logic [ModeWidth-1:0] MODE_SHORT   = 3'd3;
  localparam logic [ModeWidth-1:0] MODE_UP      = 3'd4;

  localparam logic [CfgIdxWidth-1:0] REG_PRESS_LEVEL   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_DEBOUNCE_TIME = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_SHORT_TIME    = 2'd2;
  localparam logic [CfgIdxWidth-1:0] REG_LONG_TIME     = 2'd3;

  localparam logic [ThrWidth-1:0] DEBOUNCE_RESET = 16'd15;
  localparam logic [ThrWidth-1:0] SHORT_RESET    = 16'd50;
  localparam logic [ThrWidth-1:0] LONG_RESET     = 16'd1000;

  typedef struct packed {
    logic                press_level;
    logic [ThrWidth-1:0] debounce_time;
    logic [ThrWidth-1:0] short_time;
    logic [ThrWidth-1:0] long_time;
  } cfg_t;

  typedef struct packed {
    logic [ModeWidth-1:0] key_mode;
    logic                 release_event;
    logic                 long_event;
    logic                 short_event;
  } res_t;

endpackage

`default_nettype wire

@@ src/kpc_cfg_regs.sv @@
// Configuration register file for the key press classifier.
`default_nettype none

module kpc_cfg_regs (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [kpc_pkg::CfgIdxWidth-1:0]   cfg_index,
  input  wire [kpc_pkg::ThrWidth-1:0]      cfg_wdata,
  output kpc_pkg::cfg_t                    cfg
);

  kpc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_level   <= 1'b0;
      cfg_r.debounce_time <= kpc_pkg::DEBOUNCE_RESET;
      cfg_r.short_time    <= kpc_pkg::SHORT_RESET;
      cfg_r.long_time     <= kpc_pkg::LONG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kpc_pkg::REG_PRESS_LEVEL:   cfg_r.press_level   <= cfg_wdata[0];
        kpc_pkg::REG_DEBOUNCE_TIME: cfg_r.debounce_time <= cfg_wdata;
        kpc_pkg::REG_SHORT_TIME:    cfg_r.short_time    <= cfg_wdata;
        kpc_pkg::REG_LONG_TIME:     cfg_r.long_time     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ src/kpc_fsm.sv @@
// Debounce and press classification state machine, one scan per enabled cycle.
`default_nettype none

module kpc_fsm #(
  parameter int TIME_WIDTH = kpc_pkg::TimeWidthDef
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    en,
  input  wire                    key_level,
  input  wire [TIME_WIDTH-1:0]   now,
  input  wire kpc_pkg::cfg_t     cfg,
  output kpc_pkg::res_t          res
);

  logic [kpc_pkg::ModeWidth-1:0] mode_r, mode_nxt;
  logic [TIME_WIDTH-1:0]         down_start_r, down_start_nxt;
  logic [TIME_WIDTH-1:0]         hold_start_r, hold_start_nxt;
  logic [TIME_WIDTH-1:0]         up_start_r, up_start_nxt;
  logic                          long_done_r, long_done_nxt;

  logic                  pressed;
  logic [TIME_WIDTH-1:0] down_el, hold_el, up_el;
  logic [TIME_WIDTH-1:0] dbn_thr, short_thr, long_thr;
  logic                  ev_short, ev_long, ev_rel;

  assign pressed   = (key_level == cfg.press_level);
  assign down_el   = now - down_start_r;
  assign hold_el   = now - hold_start_r;
  assign up_el     = now - up_start_r;
  assign dbn_thr   = TIME_WIDTH'(cfg.debounce_time);
  assign short_thr = TIME_WIDTH'(cfg.short_time);
  assign long_thr  = TIME_WIDTH'(cfg.long_time);

  always_comb begin
    mode_nxt       = mode_r;
    down_start_nxt = down_start_r;
    hold_start_nxt = hold_start_r;
    up_start_nxt   = up_start_r;
    long_done_nxt  = long_done_r;
    ev_short       = 1'b0;
    ev_long        = 1'b0;
    ev_rel         = 1'b0;
    unique case (mode_r)
      kpc_pkg::MODE_IDLE: begin
        if (pressed) begin
          mode_nxt       = kpc_pkg::MODE_DOWN;
          down_start_nxt = now;
        end
      end
      kpc_pkg::MODE_DOWN: begin
        if (!pressed) begin
          mode_nxt = kpc_pkg::MODE_IDLE;
        end else if (down_el >= dbn_thr) begin
          mode_nxt       = kpc_pkg::MODE_PRESSED;
          hold_start_nxt = now;
          long_done_nxt  = 1'b0;
        end
      end
      kpc_pkg::MODE_PRESSED: begin
        if (!pressed) begin
          up_start_nxt = now;
          if (!long_done_r && hold_el >= short_thr) begin
            mode_nxt = kpc_pkg::MODE_SHORT;
          end else begin
            mode_nxt = kpc_pkg::MODE_UP;
          end
        end else if (!long_done_r && hold_el >= long_thr) begin
          ev_long       = 1'b1;
          long_done_nxt = 1'b1;
        end
      end
      kpc_pkg::MODE_SHORT: begin
        if (!pressed) begin
          ev_short     = 1'b1;
          mode_nxt     = kpc_pkg::MODE_UP;
          up_start_nxt = now;
        end
      end
      kpc_pkg::MODE_UP: begin
        if (pressed) begin
          mode_nxt       = kpc_pkg::MODE_DOWN;
          down_start_nxt = now;
        end else if (up_el >= dbn_thr) begin
          ev_rel   = 1'b1;
          mode_nxt = kpc_pkg::MODE_IDLE;
        end
      end
      default: begin
        mode_nxt = kpc_pkg::MODE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= kpc_pkg::MODE_IDLE;
      long_done_r <= 1'b0;
    end else if (en) begin
      mode_r      <= mode_nxt;
      long_done_r <= long_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      down_start_r <= down_start_nxt;
      hold_start_r <= hold_start_nxt;
      up_start_r   <= up_start_nxt;
    end
  end

  assign res.short_event   = ev_short;
  assign res.long_event    = ev_long;
  assign res.release_event = ev_rel;
  assign res.key_mode      = mode_nxt;

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == kpc_pkg::MODE_IDLE) || (mode_r == kpc_pkg::MODE_DOWN) ||
    (mode_r == kpc_pkg::MODE_PRESSED) || (mode_r == kpc_pkg::MODE_SHORT) ||
    (mode_r == kpc_pkg::MODE_UP))
    else $error("Mode register left the legal codes.");

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ev_short, ev_long, ev_rel}))
    else $error("More than one event in one scan.");

  a_long_once: assert property (@(posedge clk) disable iff (!rst_n)
    (en && ev_long) |=> long_done_r && (mode_r == kpc_pkg::MODE_PRESSED))
    else $error("Long press did not latch its done flag.");

  a_short_to_up: assert property (@(posedge clk) disable iff (!rst_n)
    (en && ev_short) |=> (mode_r == kpc_pkg::MODE_UP))
    else $error("Short press did not move to release debounce.");

  a_rel_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (en && ev_rel) |=> (mode_r == kpc_pkg::MODE_IDLE))
    else $error("Release did not return to idle.");

endmodule

`default_nettype wire

@@ src/key_press_classifier_core.sv @@
// Top level of the key press classifier: stream ports, scan register and result register.
`default_nettype none

// Each scan transfer carries a raw key level and a millisecond timestamp and yields exactly one
// result transfer with short, long and release event flags and the key mode after the scan.
// The block takes one scan per clock cycle while out_tready does not hold back the result;
// a result is presented once its scan has passed from the scan register through the state
// machine into the result register, and the state update of the debounce state machine sets
// that rate. Timestamp differences wrap modulo 2^TIME_WIDTH.
// Configuration writes are taken at any time but should be made only while the block is idle.

module key_press_classifier_core #(
  parameter int TIME_WIDTH = kpc_pkg::TimeWidthDef
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: key_level[0], now_ms[32:1], zero fill[39:33].
  input  wire [kpc_pkg::InDataWidth-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // Fields from bit 0: short_event[0], long_event[1], release_event[2], key_mode[5:3],
  // zero fill[7:6].
  output logic [kpc_pkg::OutDataWidth-1:0]   out_tdata,
  input  wire                                cfg_we,
  input  wire [kpc_pkg::CfgIdxWidth-1:0]     cfg_index,
  input  wire [kpc_pkg::ThrWidth-1:0]        cfg_wdata
);

  logic                          in_valid_r;
  logic                          key_r;
  logic [kpc_pkg::NowWidth-1:0]  now_r;
  logic                          out_valid_r;
  kpc_pkg::res_t                 res_r;

  logic                  adv;
  logic [TIME_WIDTH-1:0] now_w;
  kpc_pkg::cfg_t         cfg;
  kpc_pkg::res_t         res;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign now_w     = TIME_WIDTH'({32'd0, now_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      key_r <= in_tdata[0];
      now_r <= in_tdata[32:1];
    end
    if (adv) begin
      res_r <= res;
    end
  end

  kpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kpc_fsm #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .key_level (key_r),
    .now       (now_w),
    .cfg       (cfg),
    .res       (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r};

endmodule

`default_nettype wire
